// File: rtl/avgp_pkg.sv
// Shared types and constants for the 2-D average pooling block.
// Used by avg_pool_2d_top and avgp_div; depends on nothing else.
package avgp_pkg;

	localparam int PLANES      = 4;
	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int MAX_KERNEL  = 8;
	localparam int STORE_DEPTH = PLANES * MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int AVG_W   = 16;
	localparam int AREA_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int SUM_W   = AVG_W + $clog2(MAX_KERNEL * MAX_KERNEL);
	localparam int COORD_W = 11;
	localparam int CFG_W   = 6;

	localparam logic [5:0] RST_IN_HEIGHT     = 6'd32;
	localparam logic [5:0] RST_IN_WIDTH      = 6'd32;
	localparam logic [3:0] RST_KERNEL_HEIGHT = 4'd2;
	localparam logic [3:0] RST_KERNEL_WIDTH  = 4'd2;
	localparam logic [3:0] RST_STRIDE_ROWS   = 4'd2;
	localparam logic [3:0] RST_STRIDE_COLS   = 4'd2;
	localparam logic [2:0] RST_PAD_ROWS      = 3'd0;
	localparam logic [2:0] RST_PAD_COLS      = 3'd0;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_POOL  = 1'b1;

	typedef enum logic [2:0] {
		REG_IN_HEIGHT,
		REG_IN_WIDTH,
		REG_KERNEL_HEIGHT,
		REG_KERNEL_WIDTH,
		REG_STRIDE_ROWS,
		REG_STRIDE_COLS,
		REG_PAD_ROWS,
		REG_PAD_COLS
	} reg_index_t;

	typedef struct packed {
		logic              operation;
		logic [1:0]        plane_index;
		logic [4:0]        row;
		logic [4:0]        col;
		logic signed [15:0] sample;
	} in_word_t;

	typedef struct packed {
		logic signed [AVG_W-1:0] average;
		logic                    out_of_range;
	} out_word_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [AREA_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [AVG_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/avgp_div.sv
// Bit-serial divider that rounds a signed window sum by the kernel area.
// Rounds to nearest with ties away from zero; types come from avgp_pkg.
module avgp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  avgp_pkg::div_req_t req,
	output avgp_pkg::div_rsp_t rsp
);

	localparam int SW    = avgp_pkg::SUM_W;
	localparam int AW    = avgp_pkg::AREA_W;
	localparam int QW    = avgp_pkg::AVG_W;
	localparam int CNT_W = $clog2(SW + 1);

	logic [SW-1:0]    mag;
	logic [SW-1:0]    quo_q;
	logic [AW-1:0]    rem_q;
	logic [AW-1:0]    divisor_q;
	logic [AW:0]      rem_sh;
	logic [AW:0]      rem_sub;
	logic             take;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             neg_q;
	logic             done_q;
	logic [QW-1:0]    q_low;

	always_comb begin
		mag = req.dividend[SW-1] ? SW'(-req.dividend) : SW'(req.dividend);
		mag = mag + SW'(req.divisor >> 1);
	end

	assign rem_sh  = {rem_q, quo_q[SW-1]};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign take    = rem_sh >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= mag;
			rem_q     <= '0;
			divisor_q <= req.divisor;
			neg_q     <= req.dividend[SW-1];
			cnt_q     <= CNT_W'(SW);
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
			quo_q <= {quo_q[SW-2:0], take};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign q_low        = quo_q[QW-1:0];
	assign rsp.done     = done_q;
	assign rsp.quotient = signed'(neg_q ? (~q_low + 1'b1) : q_low);

endmodule

// File: rtl/avg_pool_2d_top.sv
// Top level of the 2-D average pooling block; uses avgp_pkg and avgp_div.
// Sample writes are taken one per cycle while idle; a pool request stalls input until its
// response is loaded. A served request reads its window through the store's single
// read port, one window cell a cycle, then the bit-serial divider rounds the sum.
// A request that is not served goes to ST_HOLD and answers with out_of_range set.
// Reset restores the register defaults; the sample store keeps no reset and is not cleared.
module avg_pool_2d_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  avgp_pkg::in_word_t  req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output avgp_pkg::out_word_t rsp_word,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [avgp_pkg::CFG_W-1:0] cfg_data
);

	localparam int CW   = avgp_pkg::COORD_W;
	localparam int AW   = avgp_pkg::ADDR_W;
	localparam int KI_W = $clog2(avgp_pkg::MAX_KERNEL);
	localparam int RI_W = $clog2(avgp_pkg::MAX_ROWS);
	localparam int CI_W = $clog2(avgp_pkg::MAX_COLS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_HOLD
	} state_t;

	state_t state_q;

	logic [5:0] in_height_q, in_width_q;
	logic [3:0] kernel_height_q, kernel_width_q;
	logic [3:0] stride_rows_q, stride_cols_q;
	logic [2:0] pad_rows_q, pad_cols_q;

	logic [5:0]          h_eff, w_eff;
	logic signed [CW-1:0] h_s, w_s;
	logic signed [CW-1:0] rows_slack, cols_slack;
	logic signed [CW-1:0] row_prod, col_prod;
	logic signed [CW-1:0] r0, c0;
	logic                plane_ok, kernel_ok, served;
	logic                req_accept, mem_we;
	logic [AW-1:0]       wr_addr, rd_addr;

	logic [1:0]           plane_q;
	logic signed [CW-1:0] win_r_q, win_c_q, c0_q;
	logic [KI_W-1:0]      cnt_i_q, cnt_j_q;
	logic [KI_W-1:0]      last_i, last_j;
	logic                 cell_ok;
	logic [avgp_pkg::AREA_W-1:0]    area_q;
	logic signed [avgp_pkg::SUM_W-1:0] sum_q;
	logic signed [avgp_pkg::AVG_W-1:0] res_avg_q;
	logic                 res_oor_q;

	logic [15:0]          store_mem [avgp_pkg::STORE_DEPTH];
	logic [15:0]          rd_data_s1;
	logic                 rd_hit_s1;

	logic                 rsp_valid_q;
	logic                 rsp_load;
	avgp_pkg::out_word_t  rsp_word_q;
	avgp_pkg::div_req_t   div_req;
	avgp_pkg::div_rsp_t   div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q     <= avgp_pkg::RST_IN_HEIGHT;
			in_width_q      <= avgp_pkg::RST_IN_WIDTH;
			kernel_height_q <= avgp_pkg::RST_KERNEL_HEIGHT;
			kernel_width_q  <= avgp_pkg::RST_KERNEL_WIDTH;
			stride_rows_q   <= avgp_pkg::RST_STRIDE_ROWS;
			stride_cols_q   <= avgp_pkg::RST_STRIDE_COLS;
			pad_rows_q      <= avgp_pkg::RST_PAD_ROWS;
			pad_cols_q      <= avgp_pkg::RST_PAD_COLS;
		end else if (cfg_we) begin
			case (cfg_index)
				avgp_pkg::REG_IN_HEIGHT:     in_height_q     <= cfg_data;
				avgp_pkg::REG_IN_WIDTH:      in_width_q      <= cfg_data;
				avgp_pkg::REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[3:0];
				avgp_pkg::REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[3:0];
				avgp_pkg::REG_STRIDE_ROWS:   stride_rows_q   <= cfg_data[3:0];
				avgp_pkg::REG_STRIDE_COLS:   stride_cols_q   <= cfg_data[3:0];
				avgp_pkg::REG_PAD_ROWS:      pad_rows_q      <= cfg_data[2:0];
				avgp_pkg::REG_PAD_COLS:      pad_cols_q      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		h_eff = (in_height_q > 6'(avgp_pkg::MAX_ROWS)) ? 6'(avgp_pkg::MAX_ROWS) : in_height_q;
		w_eff = (in_width_q > 6'(avgp_pkg::MAX_COLS)) ? 6'(avgp_pkg::MAX_COLS) : in_width_q;
		h_s   = signed'(CW'(h_eff));
		w_s   = signed'(CW'(w_eff));
		rows_slack = h_s + signed'(CW'({pad_rows_q, 1'b0})) - signed'(CW'(kernel_height_q));
		cols_slack = w_s + signed'(CW'({pad_cols_q, 1'b0})) - signed'(CW'(kernel_width_q));
		row_prod = signed'(CW'(req_word.row) * CW'(stride_rows_q));
		col_prod = signed'(CW'(req_word.col) * CW'(stride_cols_q));
		r0 = row_prod - signed'(CW'(pad_rows_q));
		c0 = col_prod - signed'(CW'(pad_cols_q));
		plane_ok  = int'(req_word.plane_index) < avgp_pkg::PLANES;
		kernel_ok = kernel_height_q != 4'd0 && kernel_width_q != 4'd0
			&& kernel_height_q <= 4'(avgp_pkg::MAX_KERNEL)
			&& kernel_width_q <= 4'(avgp_pkg::MAX_KERNEL)
			&& stride_rows_q != 4'd0 && stride_cols_q != 4'd0;
		served = plane_ok && kernel_ok && rows_slack >= 0 && cols_slack >= 0
			&& row_prod <= rows_slack && col_prod <= cols_slack;
	end

	assign req_stall  = state_q != ST_IDLE;
	assign req_accept = req_valid && !req_stall;
	assign mem_we     = req_accept && req_word.operation == avgp_pkg::OP_WRITE && plane_ok
		&& 6'(req_word.row) < h_eff && 6'(req_word.col) < w_eff;
	assign wr_addr = AW'((int'(req_word.plane_index) * avgp_pkg::MAX_ROWS
		+ int'(req_word.row)) * avgp_pkg::MAX_COLS + int'(req_word.col));
	assign rd_addr = AW'((int'(plane_q) * avgp_pkg::MAX_ROWS
		+ int'(win_r_q[RI_W-1:0])) * avgp_pkg::MAX_COLS + int'(win_c_q[CI_W-1:0]));

	assign cell_ok = win_r_q >= 0 && win_r_q < h_s && win_c_q >= 0 && win_c_q < w_s;
	assign last_i  = KI_W'(kernel_height_q - 4'd1);
	assign last_j  = KI_W'(kernel_width_q - 4'd1);
	assign rsp_load = state_q == ST_HOLD && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[wr_addr] <= req_word.sample;
		end
		rd_data_s1 <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rd_hit_s1   <= 1'b0;
		end else begin
			rd_hit_s1 <= state_q == ST_READ && cell_ok;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (rd_hit_s1) begin
				sum_q <= sum_q + avgp_pkg::SUM_W'(signed'(rd_data_s1));
			end
			case (state_q)
				ST_IDLE: begin
					if (req_accept && req_word.operation == avgp_pkg::OP_POOL) begin
						plane_q <= req_word.plane_index;
						win_r_q <= r0;
						win_c_q <= c0;
						c0_q    <= c0;
						cnt_i_q <= '0;
						cnt_j_q <= '0;
						sum_q   <= '0;
						area_q  <= avgp_pkg::AREA_W'(kernel_height_q)
							* avgp_pkg::AREA_W'(kernel_width_q);
						if (served) begin
							state_q <= ST_READ;
						end else begin
							res_avg_q <= '0;
							res_oor_q <= 1'b1;
							state_q   <= ST_HOLD;
						end
					end
				end
				ST_READ: begin
					if (cnt_j_q == last_j) begin
						cnt_j_q <= '0;
						cnt_i_q <= cnt_i_q + KI_W'(1);
						win_c_q <= c0_q;
						win_r_q <= win_r_q + CW'(1);
						if (cnt_i_q == last_i) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						cnt_j_q <= cnt_j_q + KI_W'(1);
						win_c_q <= win_c_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						res_avg_q <= div_rsp.quotient;
						res_oor_q <= 1'b0;
						state_q   <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (rsp_load) begin
						rsp_word_q.average      <= res_avg_q;
						rsp_word_q.out_of_range <= res_oor_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign div_req.start    = state_q == ST_DIV_GO;
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = area_q;

	avgp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

`ifndef SYNTH
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp_word.out_of_range || rsp_word.average == '0))
		else $error("flagged word carries a nonzero average");

	a_pool_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_accept && req_word.operation == avgp_pkg::OP_POOL) |=> req_stall)
		else $error("request taken without blocking the next word");

	a_hit_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_hit_s1 |-> $past(state_q == ST_READ))
		else $error("store read accumulated outside the window scan");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished while no request waits for it");
`endif

endmodule
